// ===== sv/qslerp_pkg.sv =====
// shared types, constants and the cordic angle table for the slerp core
package qslerp_pkg;

    localparam int COMP_W      = 16;
    localparam int T_ONE       = 16384;
    localparam int QUEUE_DEPTH = 4;
    localparam int SQRT_STEPS  = 29;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_LAT     = DIV_STEPS + 2;

    localparam logic [14:0] THR_RESET   = 15'd16382;
    localparam logic [33:0] DOT_LIMIT   = 34'd295279002;
    localparam logic [33:0] DOT_ONE     = 34'd268435456;
    localparam logic [35:0] CORDIC_GAIN = 36'd652032874;

    typedef struct packed {
        logic signed [COMP_W-1:0] start_w;
        logic signed [COMP_W-1:0] start_x;
        logic signed [COMP_W-1:0] start_y;
        logic signed [COMP_W-1:0] start_z;
        logic signed [COMP_W-1:0] end_w;
        logic signed [COMP_W-1:0] end_x;
        logic signed [COMP_W-1:0] end_y;
        logic signed [COMP_W-1:0] end_z;
        logic signed [COMP_W-1:0] blend_t;
    } qslerp_in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_w;
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic                     dot_too_large;
    } qslerp_out_t;

    typedef enum logic [1:0] {
        CLS_START,
        CLS_END,
        CLS_LINEAR,
        CLS_SPHERE
    } qslerp_cls_t;

    // classified request between front and back, index 3 is w and 0 is z
    typedef struct packed {
        logic [3:0][COMP_W-1:0] a;
        logic [3:0][COMP_W:0]   b;
        logic [13:0]            t;
        qslerp_cls_t            cls;
        logic                   flag;
        logic [27:0]            dot;
    } qslerp_item_t;

    // atan(2^-i) in q30, truncated
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'd843314856;
            1: v = 32'd497837829;
            2: v = 32'd263043836;
            3: v = 32'd133525158;
            4: v = 32'd67021686;
            5: v = 32'd33543515;
            6: v = 32'd16775850;
            7: v = 32'd8388437;
            8: v = 32'd4194282;
            9: v = 32'd2097149;
            default: v = (i <= 30) ? 32'((64'd1 << (30 - i)) - 64'd1) : 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/qslerp_front.sv =====
// front end: request register, dot product, sign fold and classification
module qslerp_front import qslerp_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  qslerp_in_t   in_data,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [14:0]  cfg_data,
    input  logic         q_full,
    output logic         q_push,
    output qslerp_item_t q_item
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    qslerp_in_t         d1_reg, d2_reg, d3_reg;
    logic signed [31:0] p_reg [4];
    logic signed [31:0] p_next [4];
    logic signed [33:0] dot_reg;
    logic signed [33:0] dot_next;
    qslerp_item_t       item_reg;
    qslerp_item_t       item_next;
    logic [14:0]        thr_reg;
    logic               fen;

    logic [3:0][15:0]   a1, b1, a3, b3;
    logic signed [15:0] tv;
    logic               t_low, t_high, neg;
    logic [33:0]        absd;

    assign fen       = !(v4_reg && q_full);
    assign in_ready  = fen;
    assign cfg_ready = 1'b1;
    assign q_push    = v4_reg && !q_full;
    assign q_item    = item_reg;

    assign a1 = {d1_reg.start_w, d1_reg.start_x, d1_reg.start_y, d1_reg.start_z};
    assign b1 = {d1_reg.end_w, d1_reg.end_x, d1_reg.end_y, d1_reg.end_z};
    assign a3 = {d3_reg.start_w, d3_reg.start_x, d3_reg.start_y, d3_reg.start_z};
    assign b3 = {d3_reg.end_w, d3_reg.end_x, d3_reg.end_y, d3_reg.end_z};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            p_next[i] = $signed(a1[i]) * $signed(b1[i]);
        end
        dot_next = {{2{p_reg[0][31]}}, p_reg[0]} + {{2{p_reg[1][31]}}, p_reg[1]}
                 + {{2{p_reg[2][31]}}, p_reg[2]} + {{2{p_reg[3][31]}}, p_reg[3]};
    end

    always_comb
    begin
        tv     = d3_reg.blend_t;
        t_low  = tv <= 16'sd0;
        t_high = tv >= 16'sd16384;
        neg    = dot_reg < 34'sd0;
        absd   = neg ? 34'(-dot_reg) : 34'(dot_reg);

        item_next.a    = a3;
        item_next.t    = tv[13:0];
        item_next.dot  = absd[27:0];
        item_next.flag = !t_low && !t_high && (absd >= DOT_LIMIT);
        for (int i = 0; i < 4; i++)
        begin
            // end quaternion folds onto the short arc only for a real blend
            if (!t_low && !t_high && neg)
            begin
                item_next.b[i] = 17'(-$signed({b3[i][15], b3[i]}));
            end
            else
            begin
                item_next.b[i] = {b3[i][15], b3[i]};
            end
        end
        if (t_low)
        begin
            item_next.cls = CLS_START;
        end
        else if (t_high)
        begin
            item_next.cls = CLS_END;
        end
        else if (absd > {5'b0, thr_reg, 14'b0} || absd >= DOT_ONE)
        begin
            item_next.cls = CLS_LINEAR;
        end
        else
        begin
            item_next.cls = CLS_SPHERE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            thr_reg <= THR_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            if (fen)
            begin
                v1_reg <= in_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            d1_reg   <= in_data;
            d2_reg   <= d1_reg;
            d3_reg   <= d2_reg;
            p_reg    <= p_next;
            dot_reg  <= dot_next;
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/qslerp_queue.sv =====
// short fifo between the classifying front and the arithmetic back
module qslerp_queue import qslerp_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  qslerp_item_t push_item,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output qslerp_item_t pop_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    qslerp_item_t   entry_reg [QUEUE_DEPTH];
    logic [AW-1:0]  wptr_reg, rptr_reg;
    logic [AW:0]    count_reg;

    assign full      = count_reg == (AW+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_item  = entry_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/qslerp_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module qslerp_sqrt import qslerp_pkg::*; (
    input  logic        clk,
    input  logic        en,
    input  logic [56:0] n,
    output logic [28:0] root
);

    logic [56:0] rem_reg  [SQRT_STEPS];
    logic [28:0] root_reg [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_step
        localparam int K = SQRT_STEPS - 1 - j;
        logic [56:0] remp;
        logic [28:0] rp;
        logic [58:0] trial;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign remp = n;
            assign rp   = '0;
        end
        else
        begin : g_next
            assign remp = rem_reg[j-1];
            assign rp   = root_reg[j-1];
        end

        // (r + 2^k)^2 - r^2
        assign trial = ({30'b0, rp} << (K + 1)) + (59'd1 << (2 * K));
        assign ge    = {2'b0, remp} >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? 57'({2'b0, remp} - trial) : remp;
                root_reg[j] <= ge ? (rp | (29'd1 << K)) : rp;
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule

// ===== sv/qslerp_cordic.sv =====
// pipelined cordic, vectoring for the angle or rotation for the sine
module qslerp_cordic import qslerp_pkg::*; #(
    parameter int ITER   = 16,
    parameter bit ROTATE = 1'b0
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [35:0] x_in,
    input  logic signed [35:0] y_in,
    input  logic signed [35:0] z_in,
    output logic signed [35:0] res
);

    logic signed [35:0] x_reg [ITER];
    logic signed [35:0] y_reg [ITER];
    logic signed [35:0] z_reg [ITER];

    for (genvar i = 0; i < ITER; i++)
    begin : g_stage
        logic signed [35:0] xp, yp, zp, xs, ys, at;
        logic               cw;

        if (i == 0)
        begin : g_first
            assign xp = x_in;
            assign yp = y_in;
            assign zp = z_in;
        end
        else
        begin : g_next
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
        end

        assign xs = xp >>> i;
        assign ys = yp >>> i;
        assign at = $signed({4'b0, atan_q30(i)});
        // clockwise step: drive y down when vectoring, z up when rotating
        assign cw = ROTATE ? (zp < 36'sd0) : (yp > 36'sd0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cw)
                begin
                    x_reg[i] <= xp + ys;
                    y_reg[i] <= yp - xs;
                    z_reg[i] <= zp + at;
                end
                else
                begin
                    x_reg[i] <= xp - ys;
                    y_reg[i] <= yp + xs;
                    z_reg[i] <= zp - at;
                end
            end
        end
    end

    assign res = ROTATE ? y_reg[ITER-1] : z_reg[ITER-1];

endmodule

// ===== sv/qslerp_div.sv =====
// pipelined weight divider: sat(sin * 2^28 / s) toward zero, one quotient bit per stage
module qslerp_div import qslerp_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  logic signed [35:0] num,
    input  logic [28:0]        den,
    output logic signed [32:0] k
);

    logic        neg_reg  [DIV_STEPS+1];
    logic        over_reg [DIV_STEPS+1];
    logic [3:0]  m4_reg   [DIV_STEPS+1];
    logic [28:0] den_reg  [DIV_STEPS+1];
    logic [29:0] rem_reg  [DIV_STEPS+1];
    logic [31:0] q_reg    [DIV_STEPS+1];
    logic signed [32:0] k_reg;

    logic        neg_c;
    logic [35:0] mag_c;
    logic [32:0] mq_c;
    logic        big_c;

    always_comb
    begin
        neg_c = num < 36'sd0;
        mag_c = neg_c ? 36'(-num) : 36'(num);
        big_c = over_reg[DIV_STEPS] || (q_reg[DIV_STEPS] > 32'h8000_0000);
        mq_c  = big_c ? (33'd1 << 31) : {1'b0, q_reg[DIV_STEPS]};
    end

    // quotient of 2^32 or more is caught up front
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0]  <= neg_c;
            over_reg[0] <= mag_c >= {3'b0, den, 4'b0};
            m4_reg[0]   <= mag_c[3:0];
            den_reg[0]  <= den;
            rem_reg[0]  <= mag_c[33:4];
            q_reg[0]    <= '0;
            k_reg       <= neg_reg[DIV_STEPS] ? -$signed(mq_c) : $signed(mq_c);
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_step
        localparam int QB = DIV_STEPS - j;
        logic        nb;
        logic [29:0] sh;
        logic        ge;

        if (QB >= 28)
        begin : g_num
            assign nb = m4_reg[j-1][QB-28];
        end
        else
        begin : g_zero
            assign nb = 1'b0;
        end

        assign sh = {rem_reg[j-1][28:0], nb};
        assign ge = sh >= {1'b0, den_reg[j-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[j]  <= neg_reg[j-1];
                over_reg[j] <= over_reg[j-1];
                m4_reg[j]   <= m4_reg[j-1];
                den_reg[j]  <= den_reg[j-1];
                rem_reg[j]  <= ge ? (sh - {1'b0, den_reg[j-1]}) : sh;
                q_reg[j]    <= {q_reg[j-1][30:0], ge};
            end
        end
    end

    assign k = k_reg;

endmodule

// ===== sv/qslerp_back.sv =====
// back end: angle, sine weights, blend products, rounding and the output register
module qslerp_back import qslerp_pkg::*; #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  qslerp_item_t q_item,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output qslerp_out_t  out_data
);

    localparam int CN       = TRIG_ITERATIONS;
    localparam int SQ_OUT   = 2 + SQRT_STEPS;
    localparam int ATAN_OUT = SQ_OUT + CN;
    localparam int KD       = ATAN_OUT + 1 + CN + DIV_LAT;
    localparam int SD       = 2 * CN;
    localparam logic signed [32:0] K_ONE = 33'sd1073741824;

    qslerp_item_t       sb_reg  [KD+1];
    logic               v_reg   [KD+1];
    logic [28:0]        s_d_reg [SD+1];
    logic [55:0]        csq_reg;
    logic [56:0]        n_reg;
    logic signed [35:0] ang0_reg, ang1_reg;
    logic signed [49:0] p0_reg [4];
    logic signed [49:0] p1_reg [4];
    logic               vp_reg, flagp_reg, out_valid_reg;
    qslerp_out_t        out_data_reg;
    qslerp_out_t        out_data_next;

    logic               adv;
    logic [28:0]        s_root;
    logic signed [35:0] omega, sin0, sin1;
    logic signed [32:0] kw0, kw1, k0_c, k1_c;
    logic [13:0]        ta;
    logic [14:0]        tca, tck;
    logic signed [51:0] pr0, pr1;
    qslerp_item_t       sbk;
    logic [3:0][15:0]   res_c;

    // the whole back pipe holds while a finished result is not taken
    assign adv       = !out_valid_reg || out_ready;
    assign q_pop     = adv && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    qslerp_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .n    (n_reg),
        .root (s_root)
    );

    qslerp_cordic #(.ITER(CN), .ROTATE(1'b0)) u_atan (
        .clk  (clk),
        .en   (adv),
        .x_in ($signed({8'b0, sb_reg[SQ_OUT].dot})),
        .y_in ($signed({7'b0, s_root})),
        .z_in (36'sd0),
        .res  (omega)
    );

    qslerp_cordic #(.ITER(CN), .ROTATE(1'b1)) u_sin0 (
        .clk  (clk),
        .en   (adv),
        .x_in ($signed(CORDIC_GAIN)),
        .y_in (36'sd0),
        .z_in (ang0_reg),
        .res  (sin0)
    );

    qslerp_cordic #(.ITER(CN), .ROTATE(1'b1)) u_sin1 (
        .clk  (clk),
        .en   (adv),
        .x_in ($signed(CORDIC_GAIN)),
        .y_in (36'sd0),
        .z_in (ang1_reg),
        .res  (sin1)
    );

    qslerp_div u_div0 (
        .clk (clk),
        .en  (adv),
        .num (sin0),
        .den (s_d_reg[SD]),
        .k   (kw0)
    );

    qslerp_div u_div1 (
        .clk (clk),
        .en  (adv),
        .num (sin1),
        .den (s_d_reg[SD]),
        .k   (kw1)
    );

    always_comb
    begin
        ta  = sb_reg[ATAN_OUT].t;
        tca = 15'(T_ONE) - {1'b0, ta};
        pr1 = $signed({2'b0, ta}) * omega;
        pr0 = $signed({1'b0, tca}) * omega;
    end

    always_comb
    begin
        sbk = sb_reg[KD];
        tck = 15'(T_ONE) - {1'b0, sbk.t};
        case (sbk.cls)
            CLS_START:
            begin
                k0_c = K_ONE;
                k1_c = 33'sd0;
            end
            CLS_END:
            begin
                k0_c = 33'sd0;
                k1_c = K_ONE;
            end
            CLS_LINEAR:
            begin
                k0_c = $signed({2'b0, tck, 16'b0});
                k1_c = $signed({3'b0, sbk.t, 16'b0});
            end
            CLS_SPHERE:
            begin
                k0_c = kw0;
                k1_c = kw1;
            end
            default:
            begin
                k0_c = 33'sd0;
                k1_c = 33'sd0;
            end
        endcase
    end

    // round half up from q44 to q14, then clamp
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic signed [50:0] r;
            logic signed [20:0] sh;
            r  = {p0_reg[i][49], p0_reg[i]} + {p1_reg[i][49], p1_reg[i]} + 51'sd536870912;
            sh = r[50:30];
            if (sh > 21'sd32767)
            begin
                res_c[i] = 16'h7fff;
            end
            else if (sh < -21'sd32768)
            begin
                res_c[i] = 16'h8000;
            end
            else
            begin
                res_c[i] = sh[15:0];
            end
        end
        out_data_next.out_w         = res_c[3];
        out_data_next.out_x         = res_c[2];
        out_data_next.out_y         = res_c[1];
        out_data_next.out_z         = res_c[0];
        out_data_next.dot_too_large = flagp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= KD; j++)
            begin
                v_reg[j] <= 1'b0;
            end
            vp_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= q_valid;
            for (int j = 1; j <= KD; j++)
            begin
                v_reg[j] <= v_reg[j-1];
            end
            vp_reg        <= v_reg[KD];
            out_valid_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[0] <= q_item;
            for (int j = 1; j <= KD; j++)
            begin
                sb_reg[j] <= sb_reg[j-1];
            end
            csq_reg    <= sb_reg[0].dot * sb_reg[0].dot;
            n_reg      <= (57'd1 << 56) - {1'b0, csq_reg};
            s_d_reg[0] <= s_root;
            for (int j = 1; j <= SD; j++)
            begin
                s_d_reg[j] <= s_d_reg[j-1];
            end
            ang0_reg <= pr0[49:14];
            ang1_reg <= pr1[49:14];
            for (int i = 0; i < 4; i++)
            begin
                p0_reg[i] <= k0_c * $signed(sbk.a[i]);
                p1_reg[i] <= k1_c * $signed(sbk.b[i]);
            end
            flagp_reg    <= sbk.flag;
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== sv/quaternion_slerp_core.sv =====
// top level of the quaternion slerp core
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    qslerp_in_t  (start, end, blend_t)
// out       output     out_valid/out_ready  qslerp_out_t (out_w..out_z, dot_too_large)
// cfg       input      cfg_valid/cfg_ready  15-bit near-parallel threshold
//
// one request per cycle sustained while results are taken; the path to a result runs
// through the 29-stage square root, the two cordic pipes of
// TRIG_ITERATIONS stages each and the 34-stage weight dividers.
// reset clears all valid flags and loads the threshold with 16382.
// a stalled output holds only the back pipe; the front keeps accepting until
// its four-entry queue and its own four stages are full.
module quaternion_slerp_core import qslerp_pkg::*; #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  qslerp_in_t  in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output qslerp_out_t out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data
);

    logic         q_full, q_push, q_pop, q_not_empty;
    qslerp_item_t q_in_item, q_out_item;

    qslerp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in_item)
    );

    qslerp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_out_item)
    );

    qslerp_back #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_item    (q_out_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== sv/qslerp_checker.sv =====
// port-level checks for the slerp core and their bind
module qslerp_checker import qslerp_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        out_valid,
    input logic        out_ready,
    input qslerp_out_t out_data
);

    logic [15:0] pending_reg;

    // requests taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 16'(in_valid && in_ready) - 16'(out_valid && out_ready);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 16'd0)
        else $error("result without a pending request");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> pending_reg >= 16'(QUEUE_DEPTH + 1))
        else $error("input stalled with queue not full");

    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("threshold write refused");

endmodule

bind quaternion_slerp_core qslerp_checker u_qslerp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== sim/quaternion_slerp_core_test.sv =====
// self-checking testbench for the quaternion slerp core
module quaternion_slerp_core_test;
    import qslerp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        qslerp_in_t  req;
        bit          typed;
        qslerp_out_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    qslerp_in_t  in_data;
    logic        out_valid;
    logic        out_ready;
    qslerp_out_t out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [14:0] cfg_data;

    qslerp_out_t expected_q[$];
    row_t        directed[$];
    logic [14:0] threshold;
    int          error_count;
    bit          steady;
    bit          hold_req;

    quaternion_slerp_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint rot_angle(input int i);
        longint tbl[10];
        tbl = '{843314856, 497837829, 263043836, 133525158, 67021686,
                33543515, 16775850, 8388437, 4194282, 2097149};
        if (i < 10)
            return tbl[i];
        return (longint'(1) << (30 - i)) - 1;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bit_pos;
        root = 0;
        bit_pos = 64'd1 << 62;
        while (bit_pos > n)
            bit_pos = bit_pos >> 2;
        while (bit_pos != 0)
        begin
            if (n >= root + bit_pos)
            begin
                n = n - (root + bit_pos);
                root = (root >> 1) + bit_pos;
            end
            else
            begin
                root = root >> 1;
            end
            bit_pos = bit_pos >> 2;
        end
        return root;
    endfunction

    function automatic longint vector_angle(input longint y, input longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += rot_angle(i);
            end
            else
            begin
                x -= ys; y += xs; z -= rot_angle(i);
            end
        end
        return z;
    endfunction

    function automatic longint rotate_sine(input longint z);
        longint x;
        longint y;
        longint xs;
        longint ys;
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= rot_angle(i);
            end
            else
            begin
                x += ys; y -= xs; z += rot_angle(i);
            end
        end
        return y;
    endfunction

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic qslerp_out_t slerp_predict(input qslerp_in_t req);
        longint           a[4];
        longint           b[4];
        longint           t;
        longint           dot;
        longint           k0;
        longint           k1;
        longint           s;
        longint           omega;
        longint           r;
        longint unsigned  c;
        logic             flag;
        logic signed [15:0] comp[4];
        qslerp_out_t      res;
        a[0] = req.start_w; a[1] = req.start_x; a[2] = req.start_y; a[3] = req.start_z;
        b[0] = req.end_w;   b[1] = req.end_x;   b[2] = req.end_y;   b[3] = req.end_z;
        t = req.blend_t;
        if (t <= 0)
        begin
            res = '{req.start_w, req.start_x, req.start_y, req.start_z, 1'b0};
            return res;
        end
        if (t >= T_ONE)
        begin
            res = '{req.end_w, req.end_x, req.end_y, req.end_z, 1'b0};
            return res;
        end
        dot = 0;
        for (int i = 0; i < 4; i++)
            dot += a[i] * b[i];
        if (dot < 0)
        begin
            for (int i = 0; i < 4; i++)
                b[i] = -b[i];
            dot = -dot;
        end
        flag = dot >= longint'(DOT_LIMIT);
        if (dot > (longint'(threshold) << 14) || dot >= longint'(DOT_ONE))
        begin
            k0 = (T_ONE - t) << 16;
            k1 = t << 16;
        end
        else
        begin
            c = dot;
            s = int_sqrt((64'd1 << 56) - c * c);
            omega = vector_angle(s, dot);
            k0 = clip((rotate_sine(((T_ONE - t) * omega) >>> 14) * (longint'(1) << 28)) / s,
                      longint'(1) << 31);
            k1 = clip((rotate_sine((t * omega) >>> 14) * (longint'(1) << 28)) / s,
                      longint'(1) << 31);
        end
        for (int i = 0; i < 4; i++)
        begin
            r = (k0 * a[i] + k1 * b[i] + (longint'(1) << 29)) >>> 30;
            // clamp to the full signed 16-bit range, low end included
            if (r > 32767)
                r = 32767;
            else if (r < -32768)
                r = -32768;
            comp[i] = 16'(r);
        end
        res = '{comp[0], comp[1], comp[2], comp[3], flag};
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        qslerp_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result, count", 1, 0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.out_w !== want.out_w)
                    report_mismatch("out_w", out_data.out_w, want.out_w);
                if (out_data.out_x !== want.out_x)
                    report_mismatch("out_x", out_data.out_x, want.out_x);
                if (out_data.out_y !== want.out_y)
                    report_mismatch("out_y", out_data.out_y, want.out_y);
                if (out_data.out_z !== want.out_z)
                    report_mismatch("out_z", out_data.out_z, want.out_z);
                if (out_data.dot_too_large !== want.dot_too_large)
                    report_mismatch("dot_too_large", out_data.dot_too_large,
                                    want.dot_too_large);
            end
        end
    end

    // result side backpressure, with one long hold when asked
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready = steady || ($urandom_range(99) >= 11);
        end
    end

    initial
    begin
        #2ms;
        $display("quaternion_slerp_core_test: errors");
        $finish;
    end

    task automatic send_request(input qslerp_in_t req, input bit typed, input qslerp_out_t want);
        while (!steady && $urandom_range(99) < 11)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = req;
        do
            @(posedge clk);
        while (!in_ready);
        expected_q.push_back(typed ? want : slerp_predict(req));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_threshold(input logic [14:0] value);
        cfg_valid = 1'b1;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        threshold = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic qslerp_in_t mk(input int sw, input int sx, input int sy, input int sz,
                                      input int ew, input int ex, input int ey, input int ez,
                                      input int t);
        qslerp_in_t req;
        req = '{16'(sw), 16'(sx), 16'(sy), 16'(sz), 16'(ew), 16'(ex), 16'(ey), 16'(ez), 16'(t)};
        return req;
    endfunction

    function automatic void unit_quat(output real q[4]);
        real n;
        n = 0.0;
        for (int i = 0; i < 4; i++)
        begin
            q[i] = real'($urandom_range(20000)) - 10000.0;
            n += q[i] * q[i];
        end
        if (n < 1.0)
        begin
            q[0] = 1.0;
            n = 1.0;
        end
        n = $sqrt(n);
        for (int i = 0; i < 4; i++)
            q[i] = q[i] / n;
    endfunction

    function automatic qslerp_in_t random_request();
        real        p[4];
        real        q[4];
        real        spread;
        real        scale;
        int         c[8];
        int         t;
        int         pick;
        qslerp_in_t req;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            req = qslerp_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
            return req;
        end
        unit_quat(p);
        unit_quat(q);
        // mix in the start so the pair lands near parallel at times
        spread = (pick < 45) ? 0.0001 * $urandom_range(100) : 1.0;
        for (int i = 0; i < 4; i++)
            q[i] = p[i] + spread * (q[i] - p[i]);
        scale = (pick > 92) ? 1.05 + 0.0001 * $urandom_range(900) : 1.0;
        if ($urandom_range(1))
            scale = -scale;
        for (int i = 0; i < 4; i++)
        begin
            c[i] = $rtoi(p[i] * 16384.0 * (scale < 0 ? -scale : scale));
            c[4 + i] = $rtoi(q[i] * 16384.0 * scale);
        end
        case ($urandom_range(19))
            0: t = -$urandom_range(32768);
            1: t = 16384 + $urandom_range(16383);
            2: t = $urandom_range(1) ? 1 : 16383;
            default: t = $urandom_range(16383, 1);
        endcase
        return mk(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], t);
    endfunction

    task automatic random_phase(input int count);
        qslerp_out_t none;
        none = '0;
        for (int i = 0; i < count; i++)
            send_request(random_request(), 1'b0, none);
    endtask

    initial
    begin
        qslerp_out_t none;
        none = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        threshold = THR_RESET;
        error_count = 0;
        steady = 1'b0;
        hold_req = 1'b0;

        directed.push_back('{mk(16384, 0, 0, 0, 0, 16384, 0, 0, 0), 1'b1,
                             '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}});
        directed.push_back('{mk(-32768, 32767, -1, 1, 5, 6, 7, 8, -32768), 1'b1,
                             '{-16'sd32768, 16'sd32767, -16'sd1, 16'sd1, 1'b0}});
        directed.push_back('{mk(1, 2, 3, 4, -16384, 0, 0, 0, 16384), 1'b1,
                             '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}});
        directed.push_back('{mk(1, 2, 3, 4, 32767, -32768, 0, -1, 32767), 1'b1,
                             '{16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 1'b0}});
        directed.push_back('{mk(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
                                -1), 1'b1, '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                                1'b0}});
        directed.push_back('{mk(16384, 0, 0, 0, 16384, 0, 0, 0, 1), 1'b0, none});
        directed.push_back('{mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16383), 1'b0, none});
        directed.push_back('{mk(16384, 0, 0, 0, 0, 16384, 0, 0, 8192), 1'b0, none});
        directed.push_back('{mk(16384, 0, 0, 0, 0, 0, 0, 16384, 4096), 1'b0, none});
        directed.push_back('{mk(11585, 11585, 0, 0, -16384, 0, 0, 0, 8192), 1'b0, none});
        directed.push_back('{mk(16384, 0, 0, 0, -16384, 0, 0, 0, 8192), 1'b0, none});
        directed.push_back('{mk(16384, 0, 0, 0, 16383, 181, 0, 0, 8192), 1'b0, none});
        directed.push_back('{mk(8192, 8192, 8192, 8192, 8192, 8192, -8192, 8192, 12288),
                             1'b0, none});
        directed.push_back('{mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 8192),
                             1'b0, none});
        directed.push_back('{mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                                3), 1'b0, none});
        directed.push_back('{mk(18022, 0, 0, 0, 16384, 0, 0, 0, 8192), 1'b0, none});
        directed.push_back('{mk(18023, 0, 0, 0, 16384, 0, 0, 0, 8192), 1'b0, none});
        directed.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 8192), 1'b0, none});
        directed.push_back('{mk(16384, 0, 0, 0, 3, 16384, 0, 0, 100), 1'b0, none});
        directed.push_back('{mk(-32768, 0, 0, 0, 32767, 0, 0, 0, 16000), 1'b0, none});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_request(directed[i].req, directed[i].typed, directed[i].want);
        random_phase(380);
        drain();

        write_threshold(15'd0);
        hold_req = 1'b1;
        random_phase(250);
        drain();

        write_threshold(15'd16384);
        steady = 1'b1;
        random_phase(250);
        steady = 1'b0;
        drain();

        write_threshold(15'd32767);
        random_phase(150);
        drain();

        write_threshold(15'($urandom_range(16384)));
        random_phase(150);
        drain();

        write_threshold(THR_RESET);
        random_phase(150);
        drain();

        if (error_count == 0)
            $display("quaternion_slerp_core_test: clean");
        else
            $display("quaternion_slerp_core_test: errors");
        $finish;
    end

endmodule
